[rtl/core/pli_pkg.sv]
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants of the piecewise-linear interpolator: word
// layouts, status codes, controller states and controller/datapath bundles.
// ----------------------------------------------------------------------------
package pli_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int DIV_CYC    = DATA_WIDTH;
  localparam int DIV_CNT_W  = $clog2(DIV_CYC);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PC_W       = 5;
  localparam logic [PC_W-1:0] PC_RESET = PC_W'(2);
  localparam logic REG_POINT_COUNT = 1'b0;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] STAT_INSIDE     = 2'd0;
  localparam logic [1:0] STAT_EXTRAP     = 2'd1;
  localparam logic [1:0] STAT_ZERO_WIDTH = 2'd2;
  localparam logic [1:0] STAT_SATURATED  = 2'd3;

  typedef struct packed {
    logic                         mode;
    logic [IDX_W-1:0]             point_index;
    logic signed [DATA_WIDTH-1:0] x_value;
    logic signed [DATA_WIDTH-1:0] y_value;
    logic signed [DATA_WIDTH-1:0] query_value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] interpolated_value;
    logic [IDX_W-1:0]             segment_index;
    logic [1:0]                   status;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK_FIRST,
    ST_CHK_LAST,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_RD_LEFT,
    ST_RD_RIGHT,
    ST_DIFF,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } fsm_state_t;

  typedef enum logic [2:0] {
    AS_FIRST,
    AS_LAST,
    AS_MID,
    AS_SEG,
    AS_SEG_NEXT
  } addr_sel_t;

  typedef struct packed {
    logic      wr_point;
    logic      ld_query;
    addr_sel_t addr_sel;
    logic      set_first;
    logic      set_last;
    logic      take_lo;
    logic      srch_cmp;
    logic      lat_left;
    logic      lat_diff;
    logic      mul;
    logic      div_step;
    logic      finish;
  } dp_cmd_t;

  typedef struct packed {
    logic below_first;
    logic at_or_above_last;
    logic range_wide;
    logic zero_width;
    logic div_last;
  } dp_stat_t;

endpackage

[rtl/core/pli_ram.sv]
// ----------------------------------------------------------------------------
// pli_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pli_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/pli_datapath.sv]
// ----------------------------------------------------------------------------
// pli_datapath
// Breakpoint tables, bisection registers, difference stage, multiplier,
// radix-4 restoring divider and the saturating result stage.
// ----------------------------------------------------------------------------
module pli_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pli_pkg::in_word_t             in_word,
  input  logic [pli_pkg::PC_W-1:0]      point_count,
  input  pli_pkg::dp_cmd_t              cmd,
  output pli_pkg::dp_stat_t             stat,
  output logic                          out_valid,
  output pli_pkg::out_word_t            out_word
);

  localparam int DW = pli_pkg::DATA_WIDTH;
  localparam int IW = pli_pkg::IDX_W;
  localparam int CW = pli_pkg::CNT_W;
  localparam int PW = pli_pkg::PROD_W;
  localparam int KW = pli_pkg::DIV_CNT_W;
  localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [PW-1:0] Q_LIM = PW'(1) << (DW + 1);

  function automatic logic [DW+PW-1:0] div_step2(input logic [DW-1:0] rem,
                                                 input logic [PW-1:0] quo,
                                                 input logic [DW-1:0] dvs);
    logic [DW:0]    sh;
    logic [DW-1:0]  r;
    logic [PW-1:0]  q;
    r = rem;
    q = quo;
    for (int k = 0; k < 2; k++) begin
      sh = {r, q[PW-1]};
      q  = {q[PW-2:0], 1'b0};
      if (sh >= {1'b0, dvs}) begin
        sh   = sh - {1'b0, dvs};
        q[0] = 1'b1;
      end
      r = sh[DW-1:0];
    end
    return {r, q};
  endfunction

  logic signed [DW-1:0] z_r, z_nxt;
  logic [CW-1:0]        n_r, n_nxt;
  logic [IW-1:0]        lo_r, lo_nxt;
  logic [IW-1:0]        hi_r, hi_nxt;
  logic [IW-1:0]        seg_r, seg_nxt;
  logic                 ext_r, ext_nxt;
  logic signed [DW-1:0] x0_r, x0_nxt;
  logic signed [DW-1:0] y0_r, y0_nxt;
  logic [DW-1:0]        mdx_r, mdx_nxt;
  logic [DW-1:0]        mdy_r, mdy_nxt;
  logic [DW-1:0]        mdz_r, mdz_nxt;
  logic                 neg_r, neg_nxt;
  logic                 zero_r, zero_nxt;
  logic [PW-1:0]        quo_r, quo_nxt;
  logic [DW-1:0]        rem_r, rem_nxt;
  logic [KW-1:0]        dcnt_r, dcnt_nxt;
  pli_pkg::out_word_t   out_word_r, out_word_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [IW-1:0]        raddr;
  logic [DW-1:0]        x_rdata;
  logic [DW-1:0]        y_rdata;
  logic signed [DW-1:0] x_rd;
  logic signed [DW-1:0] y_rd;
  logic [CW-1:0]        n_clamp;
  logic [IW:0]          mid_sum;
  logic [IW-1:0]        mid;
  logic [IW-1:0]        span;
  logic signed [DW:0]   dx_w;
  logic signed [DW:0]   dy_w;
  logic signed [DW:0]   dz_w;
  logic [DW+PW-1:0]     div_res;
  logic signed [DW+2:0] y0_e;
  logic signed [DW+2:0] q_e;
  logic signed [DW+2:0] sum_w;

  pli_ram #(.WIDTH(DW), .DEPTH(pli_pkg::MAX_POINTS)) u_x_ram (
    .clk   (clk),
    .we    (cmd.wr_point),
    .waddr (in_word.point_index),
    .wdata (in_word.x_value),
    .raddr (raddr),
    .rdata (x_rdata)
  );

  pli_ram #(.WIDTH(DW), .DEPTH(pli_pkg::MAX_POINTS)) u_y_ram (
    .clk   (clk),
    .we    (cmd.wr_point),
    .waddr (in_word.point_index),
    .wdata (in_word.y_value),
    .raddr (raddr),
    .rdata (y_rdata)
  );

  assign x_rd    = $signed(x_rdata);
  assign y_rd    = $signed(y_rdata);
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[IW:1];
  assign span    = hi_r - lo_r;

  always_comb begin
    if (CW'(point_count) < CW'(2)) begin
      n_clamp = CW'(2);
    end else if (CW'(point_count) > CW'(pli_pkg::MAX_POINTS)) begin
      n_clamp = CW'(pli_pkg::MAX_POINTS);
    end else begin
      n_clamp = CW'(point_count);
    end
  end

  always_comb begin
    unique case (cmd.addr_sel)
      pli_pkg::AS_FIRST:    raddr = '0;
      pli_pkg::AS_LAST:     raddr = IW'(n_r - CW'(1));
      pli_pkg::AS_MID:      raddr = mid;
      pli_pkg::AS_SEG:      raddr = seg_r;
      pli_pkg::AS_SEG_NEXT: raddr = seg_r + IW'(1);
      default:              raddr = '0;
    endcase
  end

  assign stat.below_first      = z_r < x_rd;
  assign stat.at_or_above_last = z_r >= x_rd;
  assign stat.range_wide       = span > IW'(1);
  assign stat.zero_width       = zero_r;
  assign stat.div_last         = dcnt_r == KW'(pli_pkg::DIV_CYC - 1);

  assign dx_w    = (DW+1)'(x_rd) - (DW+1)'(x0_r);
  assign dy_w    = (DW+1)'(y_rd) - (DW+1)'(y0_r);
  assign dz_w    = (DW+1)'(z_r) - (DW+1)'(x0_r);
  assign div_res = div_step2(rem_r, quo_r, mdx_r);

  assign y0_e  = (DW+3)'(y0_r);
  assign q_e   = $signed({1'b0, quo_r[DW+1:0]});
  assign sum_w = neg_r ? (y0_e - q_e) : (y0_e + q_e);

  always_comb begin
    z_nxt         = z_r;
    n_nxt         = n_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    seg_nxt       = seg_r;
    ext_nxt       = ext_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    mdx_nxt       = mdx_r;
    mdy_nxt       = mdy_r;
    mdz_nxt       = mdz_r;
    neg_nxt       = neg_r;
    zero_nxt      = zero_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = 1'b0;

    if (cmd.ld_query) begin
      z_nxt  = in_word.query_value;
      n_nxt  = n_clamp;
      lo_nxt = '0;
      hi_nxt = IW'(n_clamp - CW'(1));
    end
    if (cmd.set_first) begin
      seg_nxt = '0;
      ext_nxt = 1'b1;
    end
    if (cmd.set_last) begin
      seg_nxt = IW'(n_r - CW'(2));
      ext_nxt = z_r > x_rd;
    end
    if (cmd.take_lo) begin
      seg_nxt = lo_r;
      ext_nxt = 1'b0;
    end
    if (cmd.srch_cmp) begin
      if (x_rd <= z_r) begin
        lo_nxt = mid;
      end else begin
        hi_nxt = mid;
      end
    end
    if (cmd.lat_left) begin
      x0_nxt = x_rd;
      y0_nxt = y_rd;
    end
    if (cmd.lat_diff) begin
      mdx_nxt  = dx_w[DW] ? DW'(-dx_w) : DW'(dx_w);
      mdy_nxt  = dy_w[DW] ? DW'(-dy_w) : DW'(dy_w);
      mdz_nxt  = dz_w[DW] ? DW'(-dz_w) : DW'(dz_w);
      neg_nxt  = dy_w[DW] ^ dz_w[DW] ^ dx_w[DW];
      zero_nxt = dx_w == '0;
    end
    if (cmd.mul) begin
      quo_nxt  = {{DW{1'b0}}, mdy_r} * {{DW{1'b0}}, mdz_r};
      rem_nxt  = '0;
      dcnt_nxt = '0;
    end
    if (cmd.div_step) begin
      rem_nxt  = div_res[DW+PW-1:PW];
      quo_nxt  = div_res[PW-1:0];
      dcnt_nxt = dcnt_r + KW'(1);
    end
    if (cmd.finish) begin
      out_valid_nxt              = 1'b1;
      out_word_nxt.segment_index = seg_r;
      if (zero_r) begin
        out_word_nxt.interpolated_value = y0_r;
        out_word_nxt.status             = pli_pkg::STAT_ZERO_WIDTH;
      end else if (quo_r > Q_LIM) begin
        out_word_nxt.interpolated_value = neg_r ? DMIN : DMAX;
        out_word_nxt.status             = pli_pkg::STAT_SATURATED;
      end else if (sum_w > (DW+3)'(DMAX)) begin
        out_word_nxt.interpolated_value = DMAX;
        out_word_nxt.status             = pli_pkg::STAT_SATURATED;
      end else if (sum_w < (DW+3)'(DMIN)) begin
        out_word_nxt.interpolated_value = DMIN;
        out_word_nxt.status             = pli_pkg::STAT_SATURATED;
      end else begin
        out_word_nxt.interpolated_value = DW'(sum_w);
        out_word_nxt.status = ext_r ? pli_pkg::STAT_EXTRAP : pli_pkg::STAT_INSIDE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    z_r        <= z_nxt;
    n_r        <= n_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    seg_r      <= seg_nxt;
    ext_r      <= ext_nxt;
    x0_r       <= x0_nxt;
    y0_r       <= y0_nxt;
    mdx_r      <= mdx_nxt;
    mdy_r      <= mdy_nxt;
    mdz_r      <= mdz_nxt;
    neg_r      <= neg_nxt;
    zero_r     <= zero_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    dcnt_r     <= dcnt_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

[rtl/core/pli_controller.sv]
// ----------------------------------------------------------------------------
// pli_controller
// Sequencer for one word: range checks, bisection, segment fetch, multiply,
// divide and result strobe.
// ----------------------------------------------------------------------------
module pli_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              mode,
  input  pli_pkg::dp_stat_t stat,
  output pli_pkg::dp_cmd_t  cmd,
  output logic              busy
);

  pli_pkg::fsm_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pli_pkg::ST_IDLE: begin
        if (start && mode == pli_pkg::MODE_QUERY) begin
          state_nxt = pli_pkg::ST_CHK_FIRST;
        end
      end
      pli_pkg::ST_CHK_FIRST: begin
        state_nxt = stat.below_first ? pli_pkg::ST_RD_LEFT : pli_pkg::ST_CHK_LAST;
      end
      pli_pkg::ST_CHK_LAST: begin
        state_nxt = stat.at_or_above_last ? pli_pkg::ST_RD_LEFT : pli_pkg::ST_SRCH_RD;
      end
      pli_pkg::ST_SRCH_RD: begin
        state_nxt = stat.range_wide ? pli_pkg::ST_SRCH_CMP : pli_pkg::ST_RD_LEFT;
      end
      pli_pkg::ST_SRCH_CMP: state_nxt = pli_pkg::ST_SRCH_RD;
      pli_pkg::ST_RD_LEFT:  state_nxt = pli_pkg::ST_RD_RIGHT;
      pli_pkg::ST_RD_RIGHT: state_nxt = pli_pkg::ST_DIFF;
      pli_pkg::ST_DIFF:     state_nxt = pli_pkg::ST_MUL;
      pli_pkg::ST_MUL: begin
        state_nxt = stat.zero_width ? pli_pkg::ST_DONE : pli_pkg::ST_DIV;
      end
      pli_pkg::ST_DIV: begin
        if (stat.div_last) begin
          state_nxt = pli_pkg::ST_DONE;
        end
      end
      pli_pkg::ST_DONE:     state_nxt = pli_pkg::ST_IDLE;
      default:              state_nxt = pli_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.addr_sel = pli_pkg::AS_FIRST;
    busy         = state_r != pli_pkg::ST_IDLE;
    unique case (state_r)
      pli_pkg::ST_IDLE: begin
        if (start) begin
          cmd.ld_query = mode == pli_pkg::MODE_QUERY;
          cmd.wr_point = mode == pli_pkg::MODE_LOAD;
        end
      end
      pli_pkg::ST_CHK_FIRST: begin
        cmd.addr_sel  = pli_pkg::AS_LAST;
        cmd.set_first = stat.below_first;
      end
      pli_pkg::ST_CHK_LAST: begin
        cmd.set_last = stat.at_or_above_last;
      end
      pli_pkg::ST_SRCH_RD: begin
        cmd.addr_sel = pli_pkg::AS_MID;
        cmd.take_lo  = !stat.range_wide;
      end
      pli_pkg::ST_SRCH_CMP: begin
        cmd.addr_sel = pli_pkg::AS_MID;
        cmd.srch_cmp = 1'b1;
      end
      pli_pkg::ST_RD_LEFT: begin
        cmd.addr_sel = pli_pkg::AS_SEG;
      end
      pli_pkg::ST_RD_RIGHT: begin
        cmd.addr_sel = pli_pkg::AS_SEG_NEXT;
        cmd.lat_left = 1'b1;
      end
      pli_pkg::ST_DIFF:  cmd.lat_diff = 1'b1;
      pli_pkg::ST_MUL:   cmd.mul      = 1'b1;
      pli_pkg::ST_DIV:   cmd.div_step = 1'b1;
      pli_pkg::ST_DONE:  cmd.finish   = 1'b1;
      default:           cmd          = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pli_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/core/piecewise_linear_interpolator.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Breakpoint table with bisection search and linear interpolation in Q8.8.
// ----------------------------------------------------------------------------
// A load word (mode 0) writes one breakpoint in the cycle it is taken and
// leaves busy low, so loads may follow each other every cycle. A query word
// (mode 1) raises busy and its result is strobed on out_valid for one cycle
// as busy falls; the receiver has to take it then. The breakpoint tables sit
// in one-read-port RAMs, so each probe of the search takes a read state and
// a compare state, and the quotient comes from a radix-4 divider. A query
// below the first breakpoint or at or above the last skips the search; one
// inside the table makes at most ceil(log2(point_count - 1)) bisection
// probes, and a zero-width segment skips the divider.
// point_count sits at address 0 of the register port and resets to 2.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  pli_pkg::in_word_t                 in_word,
  output logic                              out_valid,
  output pli_pkg::out_word_t                out_word,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pli_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [pli_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [pli_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  logic [pli_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                     reg_sel;
  logic                     reg_wr;
  pli_pkg::dp_cmd_t         cmd;
  pli_pkg::dp_stat_t        stat;

  assign pready  = 1'b1;
  assign reg_sel = paddr[pli_pkg::CFG_ADDR_W-1:2] == pli_pkg::REG_POINT_COUNT;
  assign reg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign pc_nxt  = reg_wr ? pwdata[pli_pkg::PC_W-1:0] : pc_r;
  assign prdata  = reg_sel ? pli_pkg::CFG_DATA_W'(pc_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= pli_pkg::PC_RESET;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  pli_controller u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_word.mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  pli_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_word     (in_word),
    .point_count (pc_r),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_word    (out_word)
  );

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_result_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $fell(busy))
    else $error("result strobe without end of query");

  a_busy_ends_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("query finished without result");

  a_segment_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.segment_index <= pli_pkg::IDX_W'(pli_pkg::MAX_POINTS - 2))
    else $error("segment index beyond last segment");

endmodule

[tb/pli_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pli_checker
// Passive scoreboard for the piecewise-linear interpolator. It mirrors the
// breakpoint table and point_count from the words and register writes it
// observes. For every query word it computes the expected interpolation
// word and matches it in order against the strobed results. It also
// checks register reads and reports the failure count and the number of
// results still outstanding.
// ----------------------------------------------------------------------------
module pli_checker
  import pli_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  in_word_t              in_word,
  input  logic                  out_valid,
  input  out_word_t             out_word,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic [CFG_DATA_W-1:0] prdata,
  input  logic                  pready,
  output int                    error_count,
  output int                    pending
);

  logic signed [DATA_WIDTH-1:0] table_x [MAX_POINTS];
  logic signed [DATA_WIDTH-1:0] table_y [MAX_POINTS];
  logic [PC_W-1:0]              point_count;
  out_word_t                    expected_q [$];
  int                           failures;

  function automatic out_word_t interpolate(logic signed [DATA_WIDTH-1:0] z_in);
    out_word_t  res;
    int         n, lo, hi, mid, seg;
    longint     z, x0, x1, y0, y1, dx, dy, dz, r, q, dmax, dmin;
    logic       beyond, neg, sat;
    logic [1:0] stat;
    dmax   = (longint'(1) << (DATA_WIDTH - 1)) - 1;
    dmin   = -dmax - 1;
    beyond = 1'b0;
    sat    = 1'b0;
    n      = int'(point_count);
    if (n < 2) n = 2;
    if (n > MAX_POINTS) n = MAX_POINTS;
    z = longint'(z_in);
    if (z < longint'(table_x[0])) begin
      seg    = 0;
      beyond = 1'b1;
    end else if (z >= longint'(table_x[IDX_W'(n-1)])) begin
      seg    = n - 2;
      beyond = (z > longint'(table_x[IDX_W'(n-1)]));
    end else begin
      lo = 0;
      hi = n - 1;
      while (hi - lo > 1) begin
        mid = (lo + hi) >> 1;
        if (longint'(table_x[IDX_W'(mid)]) <= z) lo = mid;
        else hi = mid;
      end
      seg = lo;
    end
    x0 = longint'(table_x[IDX_W'(seg)]);
    x1 = longint'(table_x[IDX_W'(seg+1)]);
    y0 = longint'(table_y[IDX_W'(seg)]);
    y1 = longint'(table_y[IDX_W'(seg+1)]);
    dx = x1 - x0;
    if (dx == 0) begin
      r    = y0;
      stat = STAT_ZERO_WIDTH;
    end else begin
      dy  = y1 - y0;
      dz  = z - x0;
      neg = ((dy < 0) != (dz < 0)) != (dx < 0);
      q   = ((dy < 0 ? -dy : dy) * (dz < 0 ? -dz : dz)) / (dx < 0 ? -dx : dx);
      if (q > (longint'(1) << (DATA_WIDTH + 1))) begin
        r   = neg ? dmin : dmax;
        sat = 1'b1;
      end else begin
        r = neg ? y0 - q : y0 + q;
        if (r > dmax) begin
          r   = dmax;
          sat = 1'b1;
        end
        if (r < dmin) begin
          r   = dmin;
          sat = 1'b1;
        end
      end
      stat = sat ? STAT_SATURATED : (beyond ? STAT_EXTRAP : STAT_INSIDE);
    end
    res.interpolated_value = r[DATA_WIDTH-1:0];
    res.segment_index      = seg[IDX_W-1:0];
    res.status             = stat;
    return res;
  endfunction

  task automatic note_failure(string what, out_word_t want, out_word_t got);
    failures++;
    if (failures <= 10)
      $display("%0t %s: expected value %0d seg %0d status %0d, %s %0d seg %0d status %0d",
               $realtime, what, want.interpolated_value, want.segment_index, want.status,
               "got value", got.interpolated_value, got.segment_index, got.status);
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      for (int k = 0; k < MAX_POINTS; k++) begin
        table_x[IDX_W'(k)] = '0;
        table_y[IDX_W'(k)] = '0;
      end
      point_count = PC_RESET;
      expected_q.delete();
      failures = 0;
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          want = '0;
          note_failure("unexpected result", want, out_word);
        end else begin
          want = expected_q.pop_front();
          if (out_word.interpolated_value !== want.interpolated_value ||
              out_word.segment_index !== want.segment_index ||
              out_word.status !== want.status)
            note_failure("result mismatch", want, out_word);
        end
      end
      if (psel && penable && pready && paddr[CFG_ADDR_W-1:2] == REG_POINT_COUNT) begin
        if (pwrite) begin
          point_count = pwdata[PC_W-1:0];
        end else if (prdata !== CFG_DATA_W'(point_count)) begin
          failures++;
          if (failures <= 10)
            $display("%0t point_count read: expected %0d, got %0d",
                     $realtime, point_count, prdata);
        end
      end
      if (start && !busy) begin
        if (in_word.mode == MODE_LOAD) begin
          table_x[in_word.point_index] = in_word.x_value;
          table_y[in_word.point_index] = in_word.y_value;
        end else begin
          expected_q.push_back(interpolate(in_word.query_value));
        end
      end
    end
    error_count <= failures;
    pending     <= expected_q.size();
  end

endmodule

[tb/tb_piecewise_linear_interpolator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_interpolator
// Stimulus and verdict for the piecewise-linear interpolator. A short
// directed sequence covers node hits, both extrapolation sides, saturation
// and a zero-width segment. Random phases follow: each reprograms
// point_count, loads a fresh breakpoint table (sorted, with repeated
// abscissae, or unsorted) and fires queries around it, with varying sender
// gaps. Checking is done by pli_checker.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_interpolator;
  import pli_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] PC_ADDR = {REG_POINT_COUNT, 2'b00};

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  in_word_t                     in_word;
  logic                         out_valid;
  out_word_t                    out_word;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [CFG_ADDR_W-1:0]        paddr;
  logic [CFG_DATA_W-1:0]        pwdata;
  logic [CFG_DATA_W-1:0]        prdata;
  logic                         pready;
  int                           error_count;
  int                           pending;
  int                           idle_pct;
  int                           active_points;
  logic signed [DATA_WIDTH-1:0] node_x [MAX_POINTS];

  piecewise_linear_interpolator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  pli_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_word    (out_word),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .error_count (error_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_word(input in_word_t w);
    while (int'($urandom_range(99)) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic load_point(input int slot, input int xv, input int yv);
    in_word_t w;
    w.mode        = MODE_LOAD;
    w.point_index = slot[IDX_W-1:0];
    w.x_value     = xv[DATA_WIDTH-1:0];
    w.y_value     = yv[DATA_WIDTH-1:0];
    w.query_value = DATA_WIDTH'($urandom);
    node_x[slot[IDX_W-1:0]] = xv[DATA_WIDTH-1:0];
    send_word(w);
  endtask

  task automatic query(input int zv);
    in_word_t w;
    w.mode        = MODE_QUERY;
    w.point_index = IDX_W'($urandom);
    w.x_value     = DATA_WIDTH'($urandom);
    w.y_value     = DATA_WIDTH'($urandom);
    w.query_value = zv[DATA_WIDTH-1:0];
    send_word(w);
  endtask

  task automatic cfg_access(input logic wr, input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PC_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // drain outstanding queries, then reprogram point_count and read it back
  task automatic set_points(input int count);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_access(1'b1, CFG_DATA_W'(count));
    cfg_access(1'b0, '0);
    active_points = count < 2 ? 2 : (count > MAX_POINTS ? MAX_POINTS : count);
  endtask

  task automatic load_table();
    int kind, spread, xv, yv, step;
    logic narrow_y;
    kind     = $urandom_range(99);
    narrow_y = 1'($urandom_range(1));
    case ($urandom_range(2))
      0: spread = 16;
      1: spread = 256;
      default: spread = 4096;
    endcase
    xv = int'($urandom_range(65535 - 15 * spread)) - 32768;
    for (int k = 0; k < MAX_POINTS; k++) begin
      yv = narrow_y ? int'($urandom_range(4095)) - 2048 : int'($urandom_range(65535)) - 32768;
      if (kind < 15) begin
        load_point(k, int'($urandom_range(65535)) - 32768, yv);
      end else begin
        load_point(k, xv, yv);
        step = (kind < 30 && $urandom_range(3) == 0) ? 0 : $urandom_range(1, spread);
        xv += step;
      end
    end
  endtask

  function automatic int pick_query();
    int sel, lo, hi, v;
    sel = $urandom_range(99);
    lo  = int'(node_x[0]);
    hi  = int'(node_x[IDX_W'(active_points-1)]);
    if (sel < 20)
      v = int'($urandom_range(65535)) - 32768;
    else if (sel < 40)
      v = int'(node_x[IDX_W'($urandom_range(active_points - 1))]);
    else if (sel < 90 && hi >= lo)
      v = lo + int'($urandom_range(hi - lo));
    else if ($urandom_range(1))
      v = lo - int'($urandom_range(1, 64));
    else
      v = hi + int'($urandom_range(1, 64));
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v;
  endfunction

  initial begin
    int count_extremes [6];
    int settings_done;
    count_extremes = '{0, 1, 2, 16, 17, 31};
    settings_done  = 0;
    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_word  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    idle_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_points(4);
    load_point(0, -256, 0);
    load_point(1, 0, 256);
    load_point(2, 256, -32768);
    load_point(3, 512, 32767);
    load_point(15, 32767, -1);
    query(-32768);
    query(-257);
    query(-256);
    query(-128);
    query(0);
    query(128);
    query(256);
    query(384);
    query(512);
    query(513);
    query(32767);
    // repeated abscissa on the first segment
    load_point(1, -256, 100);
    query(-300);
    query(-32768);
    query(-200);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 29 : (phase == 1) ? 57 : 0;
      for (int s = 0; s < 8; s++) begin
        if (settings_done < 6)
          set_points(count_extremes[3'(settings_done)]);
        else if ($urandom_range(3) == 0)
          set_points($urandom_range(1) ? 2 : 16);
        else
          set_points($urandom_range(2, 16));
        settings_done++;
        load_table();
        repeat (34) begin
          if ($urandom_range(19) == 0)
            load_point($urandom_range(MAX_POINTS - 1), int'($urandom_range(65535)) - 32768,
                       int'($urandom_range(65535)) - 32768);
          else
            query(pick_query());
        end
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (error_count == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/pli_pkg.sv
rtl/core/pli_ram.sv
rtl/core/pli_datapath.sv
rtl/core/pli_controller.sv
rtl/core/piecewise_linear_interpolator.sv
tb/pli_checker.sv
tb/tb_piecewise_linear_interpolator.sv
